/* hdl/sqltok_pkg.sv */
// Package with shared types, constants and keyword table for the SQL tokenizer.
`default_nettype none
package sqltok_pkg;
   localparam int KEYWORD_CHARS_DEFAULT = 7;
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam logic [3:0] TAB_WIDTH_RESET = 4'd4;
   localparam int MAX_RESULTS = 3;
   localparam int KEYWORD_COUNT = 14;

   typedef enum logic [6:0] {
      MODE_IDLE       = 7'b0000001,
      MODE_WORD       = 7'b0000010,
      MODE_NUMBER     = 7'b0000100,
      MODE_BANG       = 7'b0001000,
      MODE_STRING     = 7'b0010000,
      MODE_ESCAPE     = 7'b0100000,
      MODE_QUOTE_SEEN = 7'b1000000
   } mode_type;

   localparam logic [4:0] KIND_BANG          = 5'd5;
   localparam logic [4:0] KIND_NOT_EQUAL     = 5'd6;
   localparam logic [4:0] KIND_FIRST_KEYWORD = 5'd14;
   localparam logic [4:0] KIND_STRING        = 5'd28;
   localparam logic [4:0] KIND_INTEGER       = 5'd29;
   localparam logic [4:0] KIND_ILLEGAL       = 5'd30;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_ILLEGAL   = 2'd1;
   localparam logic [1:0] ERR_UNTERM    = 2'd2;
   localparam logic [1:0] ERR_BACKSLASH = 2'd3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_TAB       = 8'h09;

   // One result as it leaves the block.
   typedef struct packed {
      logic        is_header;
      logic [7:0]  data_byte;
      logic [4:0]  token_kind;
      logic [15:0] token_line;
      logic [15:0] token_column;
      logic [15:0] token_length;
      logic [1:0]  error_code;
      logic        last_result;
   } result_type;

   // Keyword text, left aligned, padded with zero bytes.
   function automatic logic [55:0] keyword_text(input int idx);
      logic [55:0] t;
      t = '0;
      unique case (idx)
         0:  t = {"CREATE", 8'h0};
         1:  t = {"TABLE", 16'h0};
         2:  t = {"SELECT", 8'h0};
         3:  t = {"FROM", 24'h0};
         4:  t = {"INSERT", 8'h0};
         5:  t = {"INTO", 24'h0};
         6:  t = {"VALUES", 8'h0};
         7:  t = {"WHERE", 16'h0};
         8:  t = {"ALTER", 16'h0};
         9:  t = {"ADD", 32'h0};
         10: t = {"COLUMN", 8'h0};
         11: t = {"DEFAULT"};
         12: t = {"true", 24'h0};
         default: t = {"false", 16'h0};
      endcase
      return t;
   endfunction

   function automatic logic [2:0] keyword_len(input int idx);
      logic [2:0] n;
      unique case (idx)
         0, 2, 4, 6, 10: n = 3'd6;
         1, 7, 8, 13:    n = 3'd5;
         3, 5, 12:       n = 3'd4;
         9:              n = 3'd3;
         default:        n = 3'd7;
      endcase
      return n;
   endfunction

   // Operator code for single-character operators; valid flag in the top bit.
   function automatic logic [5:0] op_code(input logic [7:0] c);
      logic [5:0] r;
      unique case (c)
         "<":     r = {1'b1, 5'd0};
         ">":     r = {1'b1, 5'd1};
         "*":     r = {1'b1, 5'd2};
         "/":     r = {1'b1, 5'd3};
         "+":     r = {1'b1, 5'd4};
         "=":     r = {1'b1, 5'd7};
         ".":     r = {1'b1, 5'd8};
         "-":     r = {1'b1, 5'd9};
         "(":     r = {1'b1, 5'd10};
         ")":     r = {1'b1, 5'd11};
         ";":     r = {1'b1, 5'd12};
         ",":     r = {1'b1, 5'd13};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
endpackage
`default_nettype wire

/* hdl/sqltok_if.sv */
// Valid/ready channel interfaces for the tokenizer's input and result streams.
`default_nettype none
interface sqltok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       first_of_text;
   logic       last_of_text;
   modport source (output valid, text_byte, first_of_text, last_of_text, input ready);
   modport sink (input valid, text_byte, first_of_text, last_of_text, output ready);
endinterface

interface sqltok_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_header;
   logic [7:0]  data_byte;
   logic [4:0]  token_kind;
   logic [15:0] token_line;
   logic [15:0] token_column;
   logic [15:0] token_length;
   logic [1:0]  error_code;
   logic        last_result;
   modport source (output valid, is_header, data_byte, token_kind, token_line,
                   token_column, token_length, error_code, last_result, input ready);
   modport sink (input valid, is_header, data_byte, token_kind, token_line,
                 token_column, token_length, error_code, last_result, output ready);
endinterface
`default_nettype wire

/* hdl/sqltok_lexer.sv */
// Lexer core: state registers and the per-item decision producing up to three results.
`default_nettype none
module sqltok_lexer #(
   parameter int KEYWORD_CHARS = sqltok_pkg::KEYWORD_CHARS_DEFAULT,
   parameter int COUNT_WIDTH   = sqltok_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [3:0]             tab_width,
   input  wire logic                   step,
   input  wire logic [7:0]             text_byte,
   input  wire logic                   first_of_text,
   input  wire logic                   last_of_text,
   output sqltok_pkg::result_type [sqltok_pkg::MAX_RESULTS-1:0] results,
   output logic [1:0]                  result_count
);
   import sqltok_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam int IW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

   mode_type                 mode_ff, mode_in;
   logic                     quote_ff, quote_in;
   logic [COUNT_WIDTH-1:0]   line_ff, line_in;
   logic [COUNT_WIDTH-1:0]   col_ff, col_in;
   logic [COUNT_WIDTH-1:0]   sline_ff, sline_in;
   logic [COUNT_WIDTH-1:0]   scol_ff, scol_in;
   logic [COUNT_WIDTH-1:0]   run_ff, run_in;
   logic                     halted_ff, halted_in;
   logic [7:0]               word_ff [KEYWORD_CHARS];
   logic                     wr_en;
   logic [IW-1:0]            wr_idx;
   logic [7:0]               wr_byte;
   logic [55:0]              store_now;

   // Keyword match of a stored word of the given length against the table.
   function automatic logic [4:0] match_word(input logic [55:0] w,
                                             input logic [COUNT_WIDTH-1:0] len);
      logic        hit;
      logic [4:0]  kind;
      logic [55:0] t;
      kind = KIND_STRING;
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
         t   = keyword_text(k);
         hit = (len == COUNT_WIDTH'(keyword_len(k)));
         for (int i = 0; i < 7; i++) begin
            if (i < int'(keyword_len(k)))
               hit = hit && (w[55-8*i -: 8] == t[55-8*i -: 8]);
         end
         if (hit) kind = KIND_FIRST_KEYWORD + 5'(k);
      end
      return kind;
   endfunction

   // The first seven bytes of the word store, as the keywords need them.
   always_comb begin
      for (int i = 0; i < 7; i++) store_now[55-8*i -: 8] = word_ff[i];
   end

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v,
                                                      input logic [3:0] d);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, v} + (COUNT_WIDTH+1)'(d);
      return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
   endfunction

   // Next state and results for one accepted item.
   always_comb begin
      mode_type    m;
      logic [7:0]  c;
      logic [7:0]  q;
      logic        idle_go;
      logic [5:0]  op;
      logic [1:0]  n;
      logic        adv;
      result_type  r;
      logic [55:0] view;

      mode_in   = mode_ff;
      quote_in  = quote_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      sline_in  = sline_ff;
      scol_in   = scol_ff;
      run_in    = run_ff;
      halted_in = halted_ff;
      wr_en     = 1'b0;
      wr_idx    = IW'(run_ff);
      wr_byte   = text_byte;
      results   = '0;
      n         = '0;
      c         = text_byte;
      m         = mode_ff;
      idle_go   = 1'b0;
      adv       = 1'b0;
      op        = op_code(c);
      r         = '0;
      view      = '0;

      if (first_of_text) begin
         line_in   = COUNT_WIDTH'(1);
         col_in    = '0;
         halted_in = 1'b0;
         m         = MODE_IDLE;
      end
      q = quote_ff ? 8'h22 : 8'h27;
      mode_in = m;

      if (!halted_in) begin
         // Header for a token closed by this byte.
         r           = '0;
         r.is_header = 1'b1;
         r.token_line   = 16'(sline_ff);
         r.token_column = 16'(scol_ff);
         unique case (m)
            MODE_WORD: begin
               if (is_letter(c) || c == "_") begin
                  results[n] = '0; results[n].data_byte = c; n = n + 2'd1;
                  run_in = sat_inc(run_ff, 4'd1);
                  wr_en = (run_ff < COUNT_WIDTH'(KEYWORD_CHARS));
                  adv = 1'b1;
               end else begin
                  r.token_kind = (run_ff > COUNT_WIDTH'(KEYWORD_CHARS)) ? KIND_STRING
                                                         : match_word(store_now, run_ff);
                  r.token_length = 16'(run_ff);
                  results[n] = r; n = n + 2'd1;
                  idle_go = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c)) begin
                  results[n] = '0; results[n].data_byte = c; n = n + 2'd1;
                  run_in = sat_inc(run_ff, 4'd1);
                  adv = 1'b1;
               end else begin
                  r.token_kind = KIND_INTEGER;
                  r.token_length = 16'(run_ff);
                  results[n] = r; n = n + 2'd1;
                  idle_go = 1'b1;
               end
            end
            MODE_BANG: begin
               mode_in = MODE_IDLE;
               r.token_kind = (c == "=") ? KIND_NOT_EQUAL : KIND_BANG;
               results[n] = r; n = n + 2'd1;
               if (c == "=") adv = 1'b1;
               else idle_go = 1'b1;
            end
            MODE_STRING: begin
               if (c == CHAR_BACKSLASH) mode_in = MODE_ESCAPE;
               else if (c == q) mode_in = MODE_QUOTE_SEEN;
               else begin
                  results[n] = '0; results[n].data_byte = c; n = n + 2'd1;
                  run_in = sat_inc(run_ff, 4'd1);
               end
               adv = 1'b1;
            end
            MODE_ESCAPE: begin
               if (c == CHAR_BACKSLASH || c == "n") begin
                  results[n] = '0;
                  results[n].data_byte = (c == "n") ? CHAR_LF : CHAR_BACKSLASH;
                  n = n + 2'd1;
                  run_in = sat_inc(run_ff, 4'd1);
               end
               mode_in = MODE_STRING;
               adv = 1'b1;
            end
            MODE_QUOTE_SEEN: begin
               if (c == q) begin
                  results[n] = '0; results[n].data_byte = c; n = n + 2'd1;
                  run_in = sat_inc(run_ff, 4'd1);
                  mode_in = MODE_STRING;
                  adv = 1'b1;
               end else begin
                  r.token_kind = KIND_STRING;
                  r.token_length = 16'(run_ff);
                  results[n] = r; n = n + 2'd1;
                  idle_go = 1'b1;
               end
            end
            default: idle_go = 1'b1;
         endcase

         // Byte lexed from the idle state.
         if (idle_go) begin
            mode_in  = MODE_IDLE;
            sline_in = line_in;
            scol_in  = col_in;
            run_in   = '0;
            adv      = 1'b1;
            r              = '0;
            r.is_header    = 1'b1;
            r.token_line   = 16'(line_in);
            r.token_column = 16'(col_in);
            if (op[5]) begin
               r.token_kind = op[4:0];
               results[n] = r; n = n + 2'd1;
            end else if (c == " " || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR) begin
               mode_in = MODE_IDLE;
            end else if (c == "!") begin
               mode_in = MODE_BANG;
            end else if (c == 8'h27 || c == 8'h22) begin
               quote_in = (c == 8'h22);
               mode_in  = MODE_STRING;
            end else if (is_letter(c)) begin
               mode_in = MODE_WORD;
               results[n] = '0; results[n].data_byte = c; n = n + 2'd1;
               run_in = COUNT_WIDTH'(1);
               wr_en  = 1'b1;
               wr_idx = '0;
            end else if (is_digit(c)) begin
               mode_in = MODE_NUMBER;
               results[n] = '0; results[n].data_byte = c; n = n + 2'd1;
               run_in = COUNT_WIDTH'(1);
            end else begin
               r.token_kind = KIND_ILLEGAL;
               r.data_byte  = c;
               r.error_code = ERR_ILLEGAL;
               results[n] = r; n = n + 2'd1;
            end
         end

         // Position tracking.
         if (adv) begin
            if (c == CHAR_LF || c == CHAR_CR) begin
               line_in = sat_inc(line_in, 4'd1);
               col_in  = '0;
            end else if (c == CHAR_TAB) begin
               col_in = sat_inc(col_in, tab_width);
            end else begin
               col_in = sat_inc(col_in, 4'd1);
            end
         end

         // Flush at the end of the text.
         if (last_of_text) begin
            r              = '0;
            r.is_header    = 1'b1;
            r.token_line   = 16'(sline_in);
            r.token_column = 16'(scol_in);
            r.token_length = 16'(run_in);
            unique case (mode_in)
               MODE_WORD: begin
                  // The word may end with the byte written in this cycle.
                  view = store_now;
                  for (int i = 0; i < 7; i++) begin
                     if (wr_en && int'(wr_idx) == i) view[55-8*i -: 8] = wr_byte;
                  end
                  r.token_kind = (run_in > COUNT_WIDTH'(KEYWORD_CHARS)) ? KIND_STRING
                                                         : match_word(view, run_in);
                  results[n] = r; n = n + 2'd1;
               end
               MODE_NUMBER: begin
                  r.token_kind = KIND_INTEGER;
                  results[n] = r; n = n + 2'd1;
               end
               MODE_BANG: begin
                  r.token_kind = KIND_BANG;
                  r.token_length = '0;
                  results[n] = r; n = n + 2'd1;
               end
               MODE_QUOTE_SEEN: begin
                  r.token_kind = KIND_STRING;
                  results[n] = r; n = n + 2'd1;
               end
               MODE_STRING: begin
                  r.token_kind = KIND_STRING;
                  r.error_code = ERR_UNTERM;
                  results[n] = r; n = n + 2'd1;
                  halted_in = 1'b1;
               end
               MODE_ESCAPE: begin
                  r.token_kind = KIND_STRING;
                  r.error_code = ERR_BACKSLASH;
                  results[n] = r; n = n + 2'd1;
                  halted_in = 1'b1;
               end
               default: ;
            endcase
            mode_in = MODE_IDLE;
         end
      end
      if (n != 2'd0) results[n - 2'd1].last_result = 1'b1;
      result_count = n;
   end

   // The word store and the word-kind match above see the same cycle's run:
   // a word flushed on its last byte needs the byte just written, so the
   // flush path compares the updated store.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         quote_ff  <= 1'b0;
         line_ff   <= COUNT_WIDTH'(1);
         col_ff    <= '0;
         sline_ff  <= '0;
         scol_ff   <= '0;
         run_ff    <= '0;
         halted_ff <= 1'b0;
      end else if (step) begin
         mode_ff   <= mode_in;
         quote_ff  <= quote_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         sline_ff  <= sline_in;
         scol_ff   <= scol_in;
         run_ff    <= run_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && wr_en) word_ff[wr_idx] <= wr_byte;
   end
endmodule
`default_nettype wire

/* hdl/sqltok_out_queue.sv */
// Result queue: holds up to eight results and hands them out one per cycle while rsp.ready is high.
`default_nettype none
module sqltok_out_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire sqltok_pkg::result_type [sqltok_pkg::MAX_RESULTS-1:0] push_data,
   input  wire logic [1:0]  push_count,
   output logic             can_push,
   sqltok_rsp_if.source     rsp
);
   import sqltok_pkg::*;

   localparam int DEPTH = 8;
   result_type  mem_ff [DEPTH];
   logic [2:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        pop;

   assign pop      = rsp.valid && rsp.ready;
   assign can_push = (cnt_ff <= 4'(DEPTH - MAX_RESULTS));
   assign rsp.valid = (cnt_ff != 4'd0);

   // Output fields straight from the head entry.
   always_comb begin
      result_type h;
      h = mem_ff[rd_ff];
      rsp.is_header    = h.is_header;
      rsp.data_byte    = h.data_byte;
      rsp.token_kind   = h.token_kind;
      rsp.token_line   = h.token_line;
      rsp.token_column = h.token_column;
      rsp.token_length = h.token_length;
      rsp.error_code   = h.error_code;
      rsp.last_result  = h.last_result;
   end

   // Pointer and count update.
   always_comb begin
      wr_in  = push ? wr_ff + 3'(push_count) : wr_ff;
      rd_in  = pop ? rd_ff + 3'd1 : rd_ff;
      cnt_in = cnt_ff + (push ? 4'(push_count) : 4'd0) - (pop ? 4'd1 : 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entries written at up to three consecutive slots.
   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < MAX_RESULTS; i++)
            if (2'(i) < push_count) mem_ff[wr_ff + 3'(i)] <= push_data[i];
      end
   end
endmodule
`default_nettype wire

/* hdl/sql_subset_tokenizer_unit.sv */
// Top level of the SQL subset tokenizer.
// Usage:
//  - req carries one byte of query text per item with first_of_text and
//    last_of_text marks; an item is taken when req.valid and req.ready are high.
//  - rsp carries results: data bytes of a token followed by its header; the
//    last result caused by an item has last_result set. Up to three per item.
//  - csr_write_enable/csr_write_data load the 4-bit tab width (reset 4).
// Path: an item is held in the input register, lexed combinationally from it,
// and its results are written into the queue once it has room; rsp shows the
// queue's head entry, which is taken at a rising edge while rsp.ready is high.
// Throughput: one item per cycle while the result queue has room for three
// results; the queue drains one result per cycle while rsp.ready is high, so
// items with several results throttle the input through req.ready.
// Reset: synchronous, active high; line 1, column 0, idle, queue empty.
// When the receiver stalls, results wait in the eight-entry queue, the input
// register holds and req.ready falls.
`default_nettype none
module sql_subset_tokenizer_unit #(
   parameter int KEYWORD_CHARS = sqltok_pkg::KEYWORD_CHARS_DEFAULT,
   parameter int COUNT_WIDTH   = sqltok_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   sqltok_req_if.sink      req,
   sqltok_rsp_if.source    rsp,
   input  wire logic       csr_write_enable,
   input  wire logic [3:0] csr_write_data
);
   import sqltok_pkg::*;

   logic [3:0]  tab_ff;
   logic        hold_ff;
   logic [7:0]  byte_ff;
   logic        first_ff, last_ff;
   logic        step, can_push;
   result_type [MAX_RESULTS-1:0] res;
   logic [1:0]  res_count;

   // Stage register is consumed when the queue has room.
   assign step      = hold_ff && can_push;
   assign req.ready = !hold_ff || can_push;

   always_ff @(posedge clock) begin
      if (reset) tab_ff <= TAB_WIDTH_RESET;
      else if (csr_write_enable) tab_ff <= csr_write_data;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) hold_ff <= 1'b0;
      else if (req.ready) hold_ff <= req.valid;
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         byte_ff  <= req.text_byte;
         first_ff <= req.first_of_text;
         last_ff  <= req.last_of_text;
      end
   end

   sqltok_lexer #(.KEYWORD_CHARS(KEYWORD_CHARS), .COUNT_WIDTH(COUNT_WIDTH)) u_lexer (
      .clock(clock), .reset(reset), .tab_width(tab_ff), .step(step),
      .text_byte(byte_ff), .first_of_text(first_ff), .last_of_text(last_ff),
      .results(res), .result_count(res_count)
   );

   sqltok_out_queue u_queue (
      .clock(clock), .reset(reset), .push(step && res_count != 2'd0),
      .push_data(res), .push_count(res_count), .can_push(can_push), .rsp(rsp)
   );
endmodule
`default_nettype wire

/* test/tb_sql_subset_tokenizer_unit.sv */
// Self-checking testbench for the SQL subset tokenizer: directed texts, random texts, checks.
`default_nettype none
module tb_sql_subset_tokenizer_unit;
   import sqltok_pkg::*;

   // Operator and punctuation token kinds, in code order.
   typedef enum logic [4:0] {
      TK_LT, TK_GT, TK_STAR, TK_SLASH, TK_PLUS, TK_BANG, TK_NE, TK_EQ,
      TK_DOT, TK_MINUS, TK_LPAREN, TK_RPAREN, TK_SEMI, TK_COMMA
   } op_kind_type;

   localparam int WORD_CHARS = 7;
   localparam int IDLE_LIMIT = 5000;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [3:0] csr_write_data;

   sqltok_req_if req ();
   sqltok_rsp_if rsp ();

   sql_subset_tokenizer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   string keyword_names [14] = '{"CREATE", "TABLE", "SELECT", "FROM", "INSERT", "INTO",
      "VALUES", "WHERE", "ALTER", "ADD", "COLUMN", "DEFAULT", "true", "false"};

   // Lexer state as the block should hold it.
   logic [3:0]  tab_cols = TAB_WIDTH_RESET;
   mode_type    lex_mode = MODE_IDLE;
   bit          double_quote = 0;
   logic [15:0] cur_line = 16'd1;
   logic [15:0] cur_col = 16'd0;
   logic [15:0] tok_line = 16'd0;
   logic [15:0] tok_col = 16'd0;
   logic [15:0] tok_len = 16'd0;
   logic [7:0]  word_buf [WORD_CHARS];
   bit          halted = 0;

   result_type step_out [$];
   result_type expected_tokens [$];

   int  send_gap_pct = 0;
   int  recv_stall_pct = 0;
   int  idle_cycles = 0;
   bit  failed = 0;

   // Clock; the single reset at the start of the run is driven in the main initial block.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] sat_add(logic [15:0] v, logic [15:0] d);
      logic [16:0] s;
      s = {1'b0, v} + {1'b0, d};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   function automatic bit letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic int op_of(logic [7:0] c);
      case (c)
         "<": return TK_LT;
         ">": return TK_GT;
         "*": return TK_STAR;
         "/": return TK_SLASH;
         "+": return TK_PLUS;
         "=": return TK_EQ;
         ".": return TK_DOT;
         "-": return TK_MINUS;
         "(": return TK_LPAREN;
         ")": return TK_RPAREN;
         ";": return TK_SEMI;
         ",": return TK_COMMA;
         default: return -1;
      endcase
   endfunction

   function automatic void move_position(logic [7:0] c);
      if (c == CHAR_LF || c == CHAR_CR) begin
         cur_line = sat_add(cur_line, 16'd1);
         cur_col = 16'd0;
      end else if (c == CHAR_TAB) begin
         cur_col = sat_add(cur_col, {12'd0, tab_cols});
      end else begin
         cur_col = sat_add(cur_col, 16'd1);
      end
   endfunction

   function automatic void put_result(bit hdr, logic [7:0] data, logic [4:0] kind,
                                      logic [15:0] ln, logic [15:0] col,
                                      logic [15:0] len, logic [1:0] err);
      result_type r;
      r = '{is_header: hdr, data_byte: data, token_kind: kind, token_line: ln,
            token_column: col, token_length: len, error_code: err, last_result: 1'b0};
      step_out.insert(step_out.size(), r);
   endfunction

   function automatic void put_data(logic [7:0] c);
      put_result(1'b0, c, 5'd0, 16'd0, 16'd0, 16'd0, ERR_NONE);
      tok_len = sat_add(tok_len, 16'd1);
   endfunction

   function automatic void put_header(logic [4:0] kind, logic [1:0] err);
      put_result(1'b1, 8'd0, kind, tok_line, tok_col, tok_len, err);
   endfunction

   function automatic void put_op(logic [4:0] kind);
      put_result(1'b1, 8'd0, kind, tok_line, tok_col, 16'd0, ERR_NONE);
   endfunction

   function automatic void put_word_byte(logic [7:0] c);
      if (tok_len < WORD_CHARS) word_buf[tok_len] = c;
      put_data(c);
   endfunction

   // Keyword lookup over the buffered first characters of a word.
   function automatic logic [4:0] word_kind();
      bit same;
      if (tok_len > WORD_CHARS) return KIND_STRING;
      for (int k = 0; k < 14; k++) begin
         if (keyword_names[k].len() == tok_len) begin
            same = 1;
            for (int i = 0; i < tok_len; i++)
               if (word_buf[i] != keyword_names[k][i]) same = 0;
            if (same) return KIND_FIRST_KEYWORD + 5'(k);
         end
      end
      return KIND_STRING;
   endfunction

   function automatic void start_token(logic [7:0] c);
      int k;
      k = op_of(c);
      tok_line = cur_line;
      tok_col = cur_col;
      tok_len = 16'd0;
      lex_mode = MODE_IDLE;
      if (k >= 0) begin
         put_op(5'(k));
      end else if (c == " " || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR) begin
         // Whitespace only moves the position.
      end else if (c == "!") begin
         lex_mode = MODE_BANG;
      end else if (c == "'" || c == "\"") begin
         double_quote = (c == "\"");
         lex_mode = MODE_STRING;
      end else if (letter(c)) begin
         lex_mode = MODE_WORD;
         put_word_byte(c);
      end else if (digit(c)) begin
         lex_mode = MODE_NUMBER;
         put_data(c);
      end else begin
         put_result(1'b1, c, KIND_ILLEGAL, tok_line, tok_col, 16'd0, ERR_ILLEGAL);
      end
      move_position(c);
   endfunction

   // Works out the results that one accepted item causes.
   function automatic void tokenize_byte(logic [7:0] c, bit first, bit last);
      logic [7:0] q;
      step_out.delete();
      if (first) begin
         cur_line = 16'd1;
         cur_col = 16'd0;
         halted = 0;
         lex_mode = MODE_IDLE;
      end
      if (halted) return;
      q = double_quote ? 8'h22 : 8'h27;
      case (lex_mode)
         MODE_WORD: begin
            if (letter(c) || c == "_") begin
               put_word_byte(c);
               move_position(c);
            end else begin
               put_header(word_kind(), ERR_NONE);
               start_token(c);
            end
         end
         MODE_NUMBER: begin
            if (digit(c)) begin
               put_data(c);
               move_position(c);
            end else begin
               put_header(KIND_INTEGER, ERR_NONE);
               start_token(c);
            end
         end
         MODE_BANG: begin
            lex_mode = MODE_IDLE;
            if (c == "=") begin
               put_op(KIND_NOT_EQUAL);
               move_position(c);
            end else begin
               put_op(KIND_BANG);
               start_token(c);
            end
         end
         MODE_STRING: begin
            if (c == CHAR_BACKSLASH) lex_mode = MODE_ESCAPE;
            else if (c == q) lex_mode = MODE_QUOTE_SEEN;
            else put_data(c);
            move_position(c);
         end
         MODE_ESCAPE: begin
            if (c == CHAR_BACKSLASH) put_data(CHAR_BACKSLASH);
            else if (c == "n") put_data(CHAR_LF);
            lex_mode = MODE_STRING;
            move_position(c);
         end
         MODE_QUOTE_SEEN: begin
            if (c == q) begin
               put_data(c);
               lex_mode = MODE_STRING;
               move_position(c);
            end else begin
               put_header(KIND_STRING, ERR_NONE);
               start_token(c);
            end
         end
         default: start_token(c);
      endcase
      if (last) begin
         case (lex_mode)
            MODE_WORD:       put_header(word_kind(), ERR_NONE);
            MODE_NUMBER:     put_header(KIND_INTEGER, ERR_NONE);
            MODE_BANG:       put_op(KIND_BANG);
            MODE_QUOTE_SEEN: put_header(KIND_STRING, ERR_NONE);
            MODE_STRING: begin
               put_header(KIND_STRING, ERR_UNTERM);
               halted = 1;
            end
            MODE_ESCAPE: begin
               put_header(KIND_STRING, ERR_BACKSLASH);
               halted = 1;
            end
            default: ;
         endcase
         lex_mode = MODE_IDLE;
      end
      if (step_out.size() > 0) step_out[$].last_result = 1'b1;
      foreach (step_out[i]) expected_tokens.insert(expected_tokens.size(), step_out[i]);
   endfunction

   // Receiver: ready changes at the falling edge.
   always @(negedge clock) begin
      rsp.ready = ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void check_field(string name, logic [15:0] exp, logic [15:0] act);
      if (exp !== act) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp, act);
         failed = 1;
      end
   endfunction

   // Compares every accepted result with the oldest outstanding one.
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_tokens.size() == 0) begin
            $error("unexpected result: header %0b data %0d kind %0d",
                   rsp.is_header, rsp.data_byte, rsp.token_kind);
            failed = 1;
         end else begin
            e = expected_tokens.pop_front();
            check_field("is_header", 16'(e.is_header), 16'(rsp.is_header));
            check_field("data_byte", 16'(e.data_byte), 16'(rsp.data_byte));
            check_field("token_kind", 16'(e.token_kind), 16'(rsp.token_kind));
            check_field("token_line", e.token_line, rsp.token_line);
            check_field("token_column", e.token_column, rsp.token_column);
            check_field("token_length", e.token_length, rsp.token_length);
            check_field("error_code", 16'(e.error_code), 16'(rsp.error_code));
            check_field("last_result", 16'(e.last_result), 16'(rsp.last_result));
         end
      end
   end

   // Watchdog on cycles where neither channel moves an item.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (!reset && idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Sends one item; called and returning at a falling edge.
   task automatic send_item(logic [7:0] c, bit first, bit last);
      while ($urandom_range(99) < send_gap_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.text_byte = c;
      req.first_of_text = first;
      req.last_of_text = last;
      req.valid = 1'b1;
      do @(posedge clock); while (!req.ready);
      tokenize_byte(c, first, last);
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic send_bytes(logic [7:0] text [$], bit first, bit last);
      foreach (text[i])
         send_item(text[i], first && i == 0, last && i == text.size() - 1);
   endtask

   task automatic send_text(string s, bit first = 1, bit last = 1);
      logic [7:0] text [$];
      for (int i = 0; i < s.len(); i++) text.insert(text.size(), s[i]);
      send_bytes(text, first, last);
   endtask

   // Waits until all results are in and the pipeline is empty.
   task automatic drain();
      while (expected_tokens.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_tab_width(logic [3:0] w);
      drain();
      csr_write_enable = 1'b1;
      csr_write_data = w;
      @(negedge clock);
      csr_write_enable = 1'b0;
      tab_cols = w;
   endtask

   task automatic test_operators();
      send_text("<>*/+=.-(),;");
      send_text("!=!a!");
   endtask

   task automatic test_strings();
      send_text("'a''b\\\\\\n\\q' \"x\"");
      send_text("\"unterminated");
      send_text("z", 0, 1);
      send_text("'tail\\");
   endtask

   task automatic test_positions();
      send_text("\t_\r\n9\x80DEFAULT", 1, 0);
      send_item(8'h00, 0, 0);
      send_item(8'hFF, 0, 0);
      send_text("ab", 0, 0);
      send_text("true", 1, 1);
   endtask

   // One random token, mostly well formed, sometimes noise.
   function automatic void random_token(ref logic [7:0] text [$]);
      int n;
      logic [7:0] quote;
      string ops;
      string escapes;
      string blanks;
      ops = "<>*/+=.-(),;";
      escapes = "\\nq";
      blanks = " \t\r\n";
      case ($urandom_range(9))
         0, 1: begin
            string kw;
            kw = keyword_names[$urandom_range(13)];
            for (int i = 0; i < kw.len(); i++) text.insert(text.size(), kw[i]);
         end
         2: begin
            n = $urandom_range(9, 1);
            for (int i = 0; i < n; i++) begin
               if (i > 0 && $urandom_range(4) == 0)
                  text.insert(text.size(), "_");
               else if ($urandom_range(1))
                  text.insert(text.size(), 8'(8'h41 + $urandom_range(25)));
               else
                  text.insert(text.size(), 8'(8'h61 + $urandom_range(25)));
            end
         end
         3: begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++)
               text.insert(text.size(), 8'(8'h30 + $urandom_range(9)));
         end
         4: text.insert(text.size(), ops[$urandom_range(11)]);
         5: begin
            text.insert(text.size(), "!");
            if ($urandom_range(1)) text.insert(text.size(), "=");
         end
         6, 7: begin
            quote = $urandom_range(1) ? 8'h22 : 8'h27;
            text.insert(text.size(), quote);
            n = $urandom_range(5);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(5))
                  0: begin
                     text.insert(text.size(), CHAR_BACKSLASH);
                     text.insert(text.size(), escapes[$urandom_range(2)]);
                  end
                  1: begin
                     text.insert(text.size(), quote);
                     text.insert(text.size(), quote);
                  end
                  default: text.insert(text.size(), 8'(8'h20 + $urandom_range(90)));
               endcase
            end
            text.insert(text.size(), quote);
         end
         8: text.insert(text.size(), 8'($urandom_range(255)));
         default: text.insert(text.size(), blanks[$urandom_range(3)]);
      endcase
      if ($urandom_range(2) == 0) text.insert(text.size(), " ");
   endfunction

   // Random texts until the given number of items has been sent.
   task automatic test_random(int items);
      int count;
      logic [7:0] text [$];
      count = 0;
      while (count < items) begin
         text.delete();
         repeat ($urandom_range(6, 1)) random_token(text);
         // Now and then end inside an open string or escape.
         case ($urandom_range(7))
            0: begin
               text.insert(text.size(), "'");
               text.insert(text.size(), "k");
            end
            1: begin
               text.insert(text.size(), "\"");
               text.insert(text.size(), CHAR_BACKSLASH);
            end
            default: ;
         endcase
         // Keep to the item budget; a cut text simply ends mid-token.
         if (text.size() > items - count) text = text[0:items-count-1];
         send_bytes(text, 1, $urandom_range(5) != 0);
         count += text.size();
      end
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.text_byte = 8'h00;
      req.first_of_text = 1'b0;
      req.last_of_text = 1'b0;
      rsp.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 4'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_gap_pct = 24;
      recv_stall_pct = 76;
      test_operators();
      test_strings();
      test_positions();
      write_tab_width(4'd15);
      test_random(6);

      send_gap_pct = 76;
      recv_stall_pct = 24;
      write_tab_width(4'd0);
      test_positions();
      test_random(5);

      send_gap_pct = 0;
      recv_stall_pct = 0;
      write_tab_width(4'd7);
      test_random(4);

      drain();
      if (failed) begin
         $display("Test completed with failures");
      end else begin
         $display("Test completed successfully");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* sql_subset_tokenizer_unit.f */
hdl/sqltok_pkg.sv
hdl/sqltok_if.sv
hdl/sqltok_lexer.sv
hdl/sqltok_out_queue.sv
hdl/sql_subset_tokenizer_unit.sv
test/tb_sql_subset_tokenizer_unit.sv
